// ----- rtl/bouncing_projectile_step_macros.svh -----
// assertion macros used by the projectile step sequencer
`ifndef BOUNCING_PROJECTILE_STEP_MACROS_SVH
`define BOUNCING_PROJECTILE_STEP_MACROS_SVH

// same-cycle implication, checked outside reset
`define BPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define BPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/bps_pkg.sv -----
// shared types, constants and saturation helpers for the projectile step block
package bps_pkg;

    // field widths
    localparam int POS_W  = 24;
    localparam int DIR_W  = 16;
    localparam int FRAC_W = 16;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 3;

    // configuration reset values
    localparam logic [14:0] GRAVITY_RST      = 15'd6144;
    localparam logic [15:0] DRAG_RST         = 16'd63854;
    localparam logic [15:0] RESTITUTION_RST  = 16'd49152;
    localparam logic [11:0] RADIUS_RST       = 12'd20;
    localparam logic [14:0] WIDTH_RST        = 15'd1280;
    localparam logic [14:0] HEIGHT_RST       = 15'd480;
    localparam logic [14:0] MIN_SPEED_RST    = 15'd82;

    // request kinds
    localparam logic REQ_LAUNCH = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // configuration register indexes
    typedef enum logic [IDX_W-1:0] {
        CFG_GRAVITY     = 3'd0,
        CFG_DRAG        = 3'd1,
        CFG_RESTITUTION = 3'd2,
        CFG_RADIUS      = 3'd3,
        CFG_WIDTH       = 3'd4,
        CFG_HEIGHT      = 3'd5,
        CFG_MIN_SPEED   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [14:0] gravity;
        logic [15:0] drag_factor;
        logic [15:0] restitution;
        logic [11:0] ball_radius;
        logic [14:0] bound_width;
        logic [14:0] bound_height;
        logic [14:0] min_speed;
    } cfg_t;

    typedef struct packed {
        logic                    req_type;
        logic [FRAC_W-1:0]       time_step;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [DIR_W-1:0] start_dir_x;
        logic signed [DIR_W-1:0] start_dir_y;
        logic [15:0]             start_speed;
    } item_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic                    visible;
        logic                    moving;
    } result_t;

    // product selected on the shared multiplier
    typedef enum logic [3:0] {
        OP_NONE,
        OP_DXX,
        OP_DYY,
        OP_MSS,
        OP_SDT,
        OP_GDT,
        OP_DRX,
        OP_DRY,
        OP_PMX,
        OP_PMY,
        OP_RFX,
        OP_RFY
    } mul_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DXX,
        S_DYY,
        S_MSS,
        S_CMP,
        S_GDT,
        S_DRX,
        S_DRY,
        S_PMX,
        S_PMY,
        S_RFX,
        S_RFY,
        S_RWB,
        S_DONE
    } state_t;

    typedef struct packed {
        logic    accept;
        mul_op_t op;
        logic    out_load;
    } cmd_t;

    typedef struct packed {
        logic moving_now;
    } status_t;

    // clamp a wide signed value to the direction range
    function automatic logic signed [DIR_W-1:0] sat_dir(input logic signed [33:0] v);
        logic signed [DIR_W-1:0] r;
        if (v > 34'sd32767)
            r = 16'sh7FFF;
        else if (v < -34'sd32768)
            r = 16'sh8000;
        else
            r = v[DIR_W-1:0];
        return r;
    endfunction

    // clamp a wide signed value to the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [26:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 27'sd8388607)
            r = 24'sh7FFFFF;
        else if (v < -27'sd8388608)
            r = 24'sh800000;
        else
            r = v[POS_W-1:0];
        return r;
    endfunction

endpackage

// ----- rtl/bps_cfg_regs.sv -----
// configuration register bank with reset values
module bps_cfg_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [bps_pkg::IDX_W-1:0] wr_index,
    input  logic [bps_pkg::CFG_W-1:0] wr_data,
    output bps_pkg::cfg_t             cfg
);

    bps_pkg::cfg_t cfg_reg;
    bps_pkg::cfg_t cfg_next;

    // decode the register index, unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                bps_pkg::CFG_GRAVITY:     cfg_next.gravity      = wr_data[14:0];
                bps_pkg::CFG_DRAG:        cfg_next.drag_factor  = wr_data;
                bps_pkg::CFG_RESTITUTION: cfg_next.restitution  = wr_data;
                bps_pkg::CFG_RADIUS:      cfg_next.ball_radius  = wr_data[11:0];
                bps_pkg::CFG_WIDTH:       cfg_next.bound_width  = wr_data[14:0];
                bps_pkg::CFG_HEIGHT:      cfg_next.bound_height = wr_data[14:0];
                bps_pkg::CFG_MIN_SPEED:   cfg_next.min_speed    = wr_data[14:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // register storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gravity      <= bps_pkg::GRAVITY_RST;
            cfg_reg.drag_factor  <= bps_pkg::DRAG_RST;
            cfg_reg.restitution  <= bps_pkg::RESTITUTION_RST;
            cfg_reg.ball_radius  <= bps_pkg::RADIUS_RST;
            cfg_reg.bound_width  <= bps_pkg::WIDTH_RST;
            cfg_reg.bound_height <= bps_pkg::HEIGHT_RST;
            cfg_reg.min_speed    <= bps_pkg::MIN_SPEED_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/bps_datapath.sv -----
// ball state, shared multiplier, writeback and wall clamp logic
module bps_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  bps_pkg::cfg_t    cfg,
    input  bps_pkg::item_t   item,
    input  bps_pkg::cmd_t    cmd,
    output bps_pkg::status_t status,
    output bps_pkg::result_t result
);

    // ball state
    logic signed [23:0] pos_x_reg, pos_x_next;
    logic signed [23:0] pos_y_reg, pos_y_next;
    logic signed [15:0] dir_x_reg, dir_x_next;
    logic signed [15:0] dir_y_reg, dir_y_next;
    logic [15:0]        speed_reg, speed_next;
    logic               visible_reg, visible_next;
    logic               moving_reg, moving_next;

    // working registers
    logic [15:0]        dt_reg, dt_next;
    logic [31:0]        acc_reg, acc_next;
    logic [31:0]        spdt_reg, spdt_next;
    logic signed [49:0] prod_reg, prod_next;
    bps_pkg::mul_op_t   wb_op_reg;
    logic               hit_x_reg, hit_x_next;
    logic               hit_y_reg, hit_y_next;
    bps_pkg::result_t   result_reg, result_next;

    // multiplier operands
    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [16:0] dx_ext, dy_ext;

    // wall tests
    logic signed [25:0] rad26, w26, h26, px26, py26;
    logic               lo_x, hi_x, lo_y, hi_y;
    logic signed [25:0] right_x, floor_y;

    // writeback sums
    logic signed [17:0] grav_sum;
    logic signed [26:0] move_x, move_y;
    logic               launch, tick;

    assign dx_ext = {dir_x_reg[15], dir_x_reg};
    assign dy_ext = {dir_y_reg[15], dir_y_reg};
    assign launch = cmd.accept && (item.req_type == bps_pkg::REQ_LAUNCH);
    assign tick   = cmd.accept && (item.req_type == bps_pkg::REQ_TICK);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            bps_pkg::OP_DXX:
            begin
                mul_a = dx_ext;
                mul_b = {{17{dir_x_reg[15]}}, dir_x_reg};
            end
            bps_pkg::OP_DYY:
            begin
                mul_a = dy_ext;
                mul_b = {{17{dir_y_reg[15]}}, dir_y_reg};
            end
            bps_pkg::OP_MSS:
            begin
                mul_a = {2'b00, cfg.min_speed};
                mul_b = {18'd0, cfg.min_speed};
            end
            bps_pkg::OP_SDT:
            begin
                mul_a = {1'b0, speed_reg};
                mul_b = {17'd0, dt_reg};
            end
            bps_pkg::OP_GDT:
            begin
                mul_a = {2'b00, cfg.gravity};
                mul_b = {17'd0, dt_reg};
            end
            bps_pkg::OP_DRX:
            begin
                mul_a = dx_ext;
                mul_b = {17'd0, cfg.drag_factor};
            end
            bps_pkg::OP_DRY:
            begin
                mul_a = dy_ext;
                mul_b = {17'd0, cfg.drag_factor};
            end
            bps_pkg::OP_PMX:
            begin
                mul_a = dx_ext;
                mul_b = {1'b0, spdt_reg};
            end
            bps_pkg::OP_PMY:
            begin
                mul_a = dy_ext;
                mul_b = {1'b0, spdt_reg};
            end
            bps_pkg::OP_RFX:
            begin
                mul_a = 17'sd0 - dx_ext;
                mul_b = {17'd0, cfg.restitution};
            end
            bps_pkg::OP_RFY:
            begin
                mul_a = 17'sd0 - dy_ext;
                mul_b = {17'd0, cfg.restitution};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // wall geometry in q.8 pixels
    assign rad26   = {6'd0, cfg.ball_radius, 8'd0};
    assign w26     = {3'd0, cfg.bound_width, 8'd0};
    assign h26     = {3'd0, cfg.bound_height, 8'd0};
    assign px26    = {{2{pos_x_reg[23]}}, pos_x_reg};
    assign py26    = {{2{pos_y_reg[23]}}, pos_y_reg};
    assign lo_x    = (px26 - rad26) <= 26'sd0;
    assign hi_x    = (px26 + rad26) >= w26;
    assign lo_y    = (py26 - rad26) <= 26'sd0;
    assign hi_y    = (py26 + rad26) >= h26;
    assign right_x = w26 - rad26;
    assign floor_y = h26 - rad26;

    // writeback arithmetic
    assign grav_sum = {{2{dir_y_reg[15]}}, dir_y_reg} + {2'b00, prod_reg[31:16]};
    assign move_x   = {{3{pos_x_reg[23]}}, pos_x_reg} + {prod_reg[49], prod_reg[49:24]};
    assign move_y   = {{3{pos_y_reg[23]}}, pos_y_reg} + {prod_reg[49], prod_reg[49:24]};

    // speed test on the squared magnitude
    assign status.moving_now = (wb_op_reg == bps_pkg::OP_MSS) &&
                               (acc_reg > {2'b00, prod_reg[29:0]});

    // next state of the ball and working registers
    always_comb
    begin
        pos_x_next   = pos_x_reg;
        pos_y_next   = pos_y_reg;
        dir_x_next   = dir_x_reg;
        dir_y_next   = dir_y_reg;
        speed_next   = speed_reg;
        visible_next = visible_reg;
        moving_next  = moving_reg;
        dt_next      = dt_reg;
        acc_next     = acc_reg;
        spdt_next    = spdt_reg;
        hit_x_next   = hit_x_reg;
        hit_y_next   = hit_y_reg;

        // item load
        if (launch)
        begin
            pos_x_next   = item.start_x;
            pos_y_next   = item.start_y;
            dir_x_next   = item.start_dir_x;
            dir_y_next   = item.start_dir_y;
            speed_next   = item.start_speed;
            visible_next = 1'b0;
            moving_next  = 1'b0;
        end
        if (tick)
        begin
            dt_next      = item.time_step;
            visible_next = visible_reg | ~lo_x;
            moving_next  = 1'b0;
        end

        // consume the product registered last cycle
        unique case (wb_op_reg)
            bps_pkg::OP_DXX: acc_next = prod_reg[31:0];
            bps_pkg::OP_DYY: acc_next = acc_reg + prod_reg[31:0];
            bps_pkg::OP_MSS: moving_next = status.moving_now;
            bps_pkg::OP_SDT: spdt_next = prod_reg[31:0];
            bps_pkg::OP_GDT: dir_y_next = bps_pkg::sat_dir({{16{grav_sum[17]}}, grav_sum});
            bps_pkg::OP_DRX: dir_x_next = bps_pkg::sat_dir(prod_reg[49:16]);
            bps_pkg::OP_DRY: dir_y_next = bps_pkg::sat_dir(prod_reg[49:16]);
            bps_pkg::OP_PMX: pos_x_next = bps_pkg::sat_pos(move_x);
            bps_pkg::OP_PMY: pos_y_next = bps_pkg::sat_pos(move_y);
            bps_pkg::OP_RFX:
            begin
                if (hit_x_reg)
                    dir_x_next = bps_pkg::sat_dir(prod_reg[49:16]);
            end
            bps_pkg::OP_RFY:
            begin
                if (hit_y_reg)
                    dir_y_next = bps_pkg::sat_dir(prod_reg[49:16]);
            end
            default: acc_next = acc_reg;
        endcase

        // wall clamp, issued alongside the reflection product
        if (cmd.op == bps_pkg::OP_RFX)
        begin
            hit_x_next = visible_reg && (lo_x || hi_x);
            if (visible_reg && lo_x)
                pos_x_next = rad26[23:0];
            else if (visible_reg && hi_x)
                pos_x_next = right_x[23:0];
        end
        if (cmd.op == bps_pkg::OP_RFY)
        begin
            hit_y_next = visible_reg && (lo_y || hi_y);
            if (visible_reg && lo_y)
                pos_y_next = rad26[23:0];
            else if (visible_reg && hi_y)
                pos_y_next = floor_y[23:0];
        end
    end

    // result capture
    always_comb
    begin
        result_next = result_reg;
        if (cmd.out_load)
        begin
            result_next.pos_x   = pos_x_reg;
            result_next.pos_y   = pos_y_reg;
            result_next.dir_x   = dir_x_reg;
            result_next.dir_y   = dir_y_reg;
            result_next.visible = visible_reg;
            result_next.moving  = moving_reg;
        end
    end

    // state and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            dir_x_reg   <= '0;
            dir_y_reg   <= '0;
            speed_reg   <= '0;
            visible_reg <= 1'b0;
            moving_reg  <= 1'b0;
            wb_op_reg   <= bps_pkg::OP_NONE;
            hit_x_reg   <= 1'b0;
            hit_y_reg   <= 1'b0;
        end
        else
        begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            dir_x_reg   <= dir_x_next;
            dir_y_reg   <= dir_y_next;
            speed_reg   <= speed_next;
            visible_reg <= visible_next;
            moving_reg  <= moving_next;
            wb_op_reg   <= cmd.op;
            hit_x_reg   <= hit_x_next;
            hit_y_reg   <= hit_y_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dt_reg     <= dt_next;
        acc_reg    <= acc_next;
        spdt_reg   <= spdt_next;
        prod_reg   <= prod_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ----- rtl/bps_ctrl.sv -----
// sequencer that steps the shared multiplier through one tick
`include "bouncing_projectile_step_macros.svh"

module bps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_valid,
    input  logic             req_type,
    output logic             in_ready,
    input  logic             m_ready,
    output logic             out_valid,
    input  bps_pkg::status_t status,
    output bps_pkg::cmd_t    cmd
);

    bps_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd.accept   = 1'b0;
        cmd.op       = bps_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            bps_pkg::S_IDLE:
            begin
                if (s_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (req_type == bps_pkg::REQ_TICK) ? bps_pkg::S_DXX
                                                                 : bps_pkg::S_DONE;
                end
            end
            bps_pkg::S_DXX:
            begin
                cmd.op     = bps_pkg::OP_DXX;
                state_next = bps_pkg::S_DYY;
            end
            bps_pkg::S_DYY:
            begin
                cmd.op     = bps_pkg::OP_DYY;
                state_next = bps_pkg::S_MSS;
            end
            bps_pkg::S_MSS:
            begin
                cmd.op     = bps_pkg::OP_MSS;
                state_next = bps_pkg::S_CMP;
            end
            bps_pkg::S_CMP:
            begin
                if (status.moving_now)
                begin
                    cmd.op     = bps_pkg::OP_SDT;
                    state_next = bps_pkg::S_GDT;
                end
                else
                begin
                    state_next = bps_pkg::S_DONE;
                end
            end
            bps_pkg::S_GDT:
            begin
                cmd.op     = bps_pkg::OP_GDT;
                state_next = bps_pkg::S_DRX;
            end
            bps_pkg::S_DRX:
            begin
                cmd.op     = bps_pkg::OP_DRX;
                state_next = bps_pkg::S_DRY;
            end
            bps_pkg::S_DRY:
            begin
                cmd.op     = bps_pkg::OP_DRY;
                state_next = bps_pkg::S_PMX;
            end
            bps_pkg::S_PMX:
            begin
                cmd.op     = bps_pkg::OP_PMX;
                state_next = bps_pkg::S_PMY;
            end
            bps_pkg::S_PMY:
            begin
                cmd.op     = bps_pkg::OP_PMY;
                state_next = bps_pkg::S_RFX;
            end
            bps_pkg::S_RFX:
            begin
                cmd.op     = bps_pkg::OP_RFX;
                state_next = bps_pkg::S_RFY;
            end
            bps_pkg::S_RFY:
            begin
                cmd.op     = bps_pkg::OP_RFY;
                state_next = bps_pkg::S_RWB;
            end
            bps_pkg::S_RWB:
            begin
                state_next = bps_pkg::S_DONE;
            end
            bps_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = bps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bps_pkg::S_IDLE;
            end
        endcase
    end

    // output word valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (m_ready)
            out_valid_next = 1'b0;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bps_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == bps_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // sequencing checks
    `BPS_ASSERT_NEXT(a_launch_to_done, s_valid && in_ready && (req_type == bps_pkg::REQ_LAUNCH), state_reg == bps_pkg::S_DONE, "launch word did not go straight to result")
    `BPS_ASSERT_NEXT(a_tick_starts, s_valid && in_ready && (req_type == bps_pkg::REQ_TICK), state_reg == bps_pkg::S_DXX, "tick word did not start the product sequence")
    `BPS_ASSERT_NEXT(a_still_skips, (state_reg == bps_pkg::S_CMP) && !status.moving_now, state_reg == bps_pkg::S_DONE, "slow ball was moved")
    `BPS_ASSERT_NOW(a_no_overwrite, cmd.out_load, !out_valid_reg || m_ready, "result overwrote a word not yet taken")
    `BPS_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_reg, "loaded result not presented")

endmodule

// ----- rtl/bouncing_projectile_step.sv -----
// top level of the bouncing projectile step block
//
// channel   dir  handshake                   contents
// s_axis    in   s_axis_tvalid/tready        request word, tuser = req_type
// m_axis    out  m_axis_tvalid/tready        ball state after the request
// cfg       in   cfg_valid/cfg_ready         register index and write data
//
// a launch goes from accept straight to the result state; a tick runs three
// products when the ball is at or below the minimum speed and all eleven when
// it moves, these dependent products sharing the single multiplier.
// reset is asynchronous and active low, and restores the register defaults.
// a finished result waits in an output register, so a stalled m_axis side
// holds only that word while the next request is already being worked.
module bouncing_projectile_step (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // time_step[15:0], start_x[39:16], start_y[63:40],
    // start_dir_x[79:64], start_dir_y[95:80], start_speed[111:96]
    input  logic [111:0] s_axis_tdata,
    // req_type[0]
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // pos_x[23:0], pos_y[47:24], dir_x[63:48], dir_y[79:64],
    // visible[80], moving[81], zero[87:82]
    output logic [87:0]  m_axis_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    bps_pkg::cfg_t    cfg;
    bps_pkg::item_t   item;
    bps_pkg::cmd_t    cmd;
    bps_pkg::status_t status;
    bps_pkg::result_t result;

    // unpack the request word
    assign item.req_type    = s_axis_tuser;
    assign item.time_step   = s_axis_tdata[15:0];
    assign item.start_x     = s_axis_tdata[39:16];
    assign item.start_y     = s_axis_tdata[63:40];
    assign item.start_dir_x = s_axis_tdata[79:64];
    assign item.start_dir_y = s_axis_tdata[95:80];
    assign item.start_speed = s_axis_tdata[111:96];

    assign cfg_ready = 1'b1;

    // configuration registers
    bps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // sequencer
    bps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_valid   (s_axis_tvalid),
        .req_type  (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .m_ready   (m_axis_tready),
        .out_valid (m_axis_tvalid),
        .status    (status),
        .cmd       (cmd)
    );

    // arithmetic and ball state
    bps_datapath u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    // pack the result word
    assign m_axis_tdata = {6'd0, result.moving, result.visible, result.dir_y,
                           result.dir_x, result.pos_y, result.pos_x};

endmodule

// ----- bench/tb_bouncing_projectile_step.sv -----
// self-checking testbench for the bouncing projectile step block
`timescale 1ns / 1ps

module tb_bouncing_projectile_step;

    localparam logic [2:0] CFG_SPARE_IDX = 3'd7;
    localparam longint POS_HI = 64'sd8388607;
    localparam longint POS_LO = -64'sd8388608;
    localparam longint DIR_HI = 64'sd32767;
    localparam longint DIR_LO = -64'sd32768;
    localparam int IDLE_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 228;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [87:0]  m_axis_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [15:0]  cfg_data;

    bouncing_projectile_step uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // register mirror
    longint grav_q, drag_q, bounce_q, radius_px, right_px, floor_px, min_speed_q;

    // ball state mirror
    longint ball_x, ball_y, heading_x, heading_y, ball_speed;
    logic   ball_seen;

    bps_pkg::item_t   pending_items[$];
    bps_pkg::result_t ball_expect[$];

    int items_pushed;
    int items_sent;
    int items_accepted;
    int regs_written;
    int words_checked;
    int error_count;
    int idle_cycles;
    int send_gap;
    int stall_left;
    int launches_done, ticks_done, moving_seen, visible_seen, settings_used;
    bit calm_stretch;

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint bounce(input longint d);
        return clamp((-d * bounce_q) >>> 16, DIR_LO, DIR_HI);
    endfunction

    // mostly short pauses, a few long ones
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        else if (r < 90)
            return $urandom_range(3, 8);
        else
            return $urandom_range(20, 60);
    endfunction

    // load on launch, else one euler step; returns the state after the word
    task automatic advance_ball(input bps_pkg::item_t it, output bps_pkg::result_t res);
        longint dt, rad, wall;
        logic   moved;
        moved = 1'b0;
        if (it.req_type == bps_pkg::REQ_LAUNCH)
        begin
            ball_x     = longint'($signed(it.start_x));
            ball_y     = longint'($signed(it.start_y));
            heading_x  = longint'($signed(it.start_dir_x));
            heading_y  = longint'($signed(it.start_dir_y));
            ball_speed = longint'(it.start_speed);
            ball_seen  = 1'b0;
            launches_done++;
        end
        else
        begin
            dt  = longint'(it.time_step);
            rad = radius_px * 256;
            ticks_done++;
            // on-screen flag uses the position before the move
            if (!ball_seen && ball_x - rad > 0)
                ball_seen = 1'b1;
            if (heading_x * heading_x + heading_y * heading_y > min_speed_q * min_speed_q)
            begin
                moved = 1'b1;
                heading_y = clamp(heading_y + ((grav_q * dt) >>> 16), DIR_LO, DIR_HI);
                heading_x = clamp((heading_x * drag_q) >>> 16, DIR_LO, DIR_HI);
                heading_y = clamp((heading_y * drag_q) >>> 16, DIR_LO, DIR_HI);
                ball_x = clamp(ball_x + ((heading_x * ball_speed * dt) >>> 24), POS_LO, POS_HI);
                ball_y = clamp(ball_y + ((heading_y * ball_speed * dt) >>> 24), POS_LO, POS_HI);
                // walls: left or top first, then right or floor
                if (ball_seen)
                begin
                    wall = right_px * 256;
                    if (ball_x - rad <= 0)
                    begin
                        ball_x    = rad;
                        heading_x = bounce(heading_x);
                    end
                    else if (ball_x + rad >= wall)
                    begin
                        ball_x    = wall - rad;
                        heading_x = bounce(heading_x);
                    end
                    wall = floor_px * 256;
                    if (ball_y - rad <= 0)
                    begin
                        ball_y    = rad;
                        heading_y = bounce(heading_y);
                    end
                    else if (ball_y + rad >= wall)
                    begin
                        ball_y    = wall - rad;
                        heading_y = bounce(heading_y);
                    end
                end
            end
        end
        res.pos_x   = ball_x[23:0];
        res.pos_y   = ball_y[23:0];
        res.dir_x   = heading_x[15:0];
        res.dir_y   = heading_y[15:0];
        res.visible = ball_seen;
        res.moving  = moved;
        if (moved)
            moving_seen++;
        if (ball_seen)
            visible_seen++;
    endtask

    task automatic flag_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on word %0d, %s: got %0h expected %0h",
                 words_checked, field, got, want);
        error_count++;
    endtask

    task automatic check_word(input logic [87:0] word);
        bps_pkg::result_t want;
        if (ball_expect.size() == 0)
        begin
            flag_mismatch("word with nothing expected", word[63:0], 0);
        end
        else
        begin
            want = ball_expect.pop_front();
            if (word[23:0] !== want.pos_x)
                flag_mismatch("pos_x", word[23:0], want.pos_x);
            if (word[47:24] !== want.pos_y)
                flag_mismatch("pos_y", word[47:24], want.pos_y);
            if (word[63:48] !== want.dir_x)
                flag_mismatch("dir_x", word[63:48], want.dir_x);
            if (word[79:64] !== want.dir_y)
                flag_mismatch("dir_y", word[79:64], want.dir_y);
            if (word[80] !== want.visible)
                flag_mismatch("visible", word[80], want.visible);
            if (word[81] !== want.moving)
                flag_mismatch("moving", word[81], want.moving);
            if (word[87:82] !== 6'd0)
                flag_mismatch("padding", word[87:82], 0);
        end
        words_checked++;
    endtask

    // sample all handshakes at the rising edge
    always @(posedge clk)
    begin
        bps_pkg::item_t   seen;
        bps_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bps_pkg::CFG_GRAVITY:     grav_q      = longint'(cfg_data[14:0]);
                    bps_pkg::CFG_DRAG:        drag_q      = longint'(cfg_data);
                    bps_pkg::CFG_RESTITUTION: bounce_q    = longint'(cfg_data);
                    bps_pkg::CFG_RADIUS:      radius_px   = longint'(cfg_data[11:0]);
                    bps_pkg::CFG_WIDTH:       right_px    = longint'(cfg_data[14:0]);
                    bps_pkg::CFG_HEIGHT:      floor_px    = longint'(cfg_data[14:0]);
                    bps_pkg::CFG_MIN_SPEED:   min_speed_q = longint'(cfg_data[14:0]);
                    default: ;
                endcase
                regs_written++;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen.req_type    = s_axis_tuser;
                seen.time_step   = s_axis_tdata[15:0];
                seen.start_x     = s_axis_tdata[39:16];
                seen.start_y     = s_axis_tdata[63:40];
                seen.start_dir_x = s_axis_tdata[79:64];
                seen.start_dir_y = s_axis_tdata[95:80];
                seen.start_speed = s_axis_tdata[111:96];
                advance_ball(seen, want);
                ball_expect.push_back(want);
                items_accepted++;
            end
            if (m_axis_tvalid && m_axis_tready)
                check_word(m_axis_tdata);
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: no handshake for %0d cycles, %0d words still expected",
                     IDLE_LIMIT, ball_expect.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // request driver, holds a word until it is taken
    always @(negedge clk)
    begin
        if (s_axis_tvalid && items_accepted != items_sent)
        begin
            // still waiting for the handshake
        end
        else if (send_gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap--;
        end
        else if (pending_items.size() > 0)
        begin
            bps_pkg::item_t it;
            it = pending_items.pop_front();
            s_axis_tdata  <= {it.start_speed, it.start_dir_y, it.start_dir_x,
                              it.start_y, it.start_x, it.time_step};
            s_axis_tuser  <= it.req_type;
            s_axis_tvalid <= 1'b1;
            items_sent++;
            send_gap = (calm_stretch || $urandom_range(0, 1)) ? 0 : pick_pause();
        end
        else
        begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (calm_stretch)
        begin
            m_axis_tready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_pause();
        end
    end

    task automatic push_item(input bps_pkg::item_t it);
        pending_items.push_back(it);
        items_pushed++;
    endtask

    // launch with a random time step, which the block ignores
    task automatic push_launch(input logic [23:0] x, input logic [23:0] y,
                               input logic [15:0] dx, input logic [15:0] dy,
                               input logic [15:0] sp);
        bps_pkg::item_t it;
        it.req_type    = bps_pkg::REQ_LAUNCH;
        it.time_step   = 16'($urandom);
        it.start_x     = x;
        it.start_y     = y;
        it.start_dir_x = dx;
        it.start_dir_y = dy;
        it.start_speed = sp;
        push_item(it);
    endtask

    // tick with random start fields, which the block ignores
    task automatic push_tick(input logic [15:0] dt);
        bps_pkg::item_t it;
        it.req_type    = bps_pkg::REQ_TICK;
        it.time_step   = dt;
        it.start_x     = 24'($urandom);
        it.start_y     = 24'($urandom);
        it.start_dir_x = 16'($urandom);
        it.start_dir_y = 16'($urandom);
        it.start_speed = 16'($urandom);
        push_item(it);
    endtask

    function automatic logic [15:0] pick_dt();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return 16'($urandom_range(500, 4400));
        else if (r < 95)
            return 16'($urandom);
        else
            return (r < 97) ? 16'h0000 : 16'hFFFF;
    endfunction

    // one launch followed by a run of ticks
    task automatic queue_flight(input bit wild);
        int span_x, span_y, x_px, y_px, n;
        if (wild)
        begin
            push_launch(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom));
        end
        else
        begin
            span_x = (right_px > 30000) ? 30000 : int'(right_px);
            span_y = (floor_px > 30000) ? 30000 : int'(floor_px);
            x_px = int'($urandom_range(0, span_x + 64)) - 64;
            y_px = int'($urandom_range(0, span_y + 64)) - 64;
            push_launch(24'(x_px * 256 + int'($urandom_range(0, 255))),
                        24'(y_px * 256 + int'($urandom_range(0, 255))),
                        16'(int'($urandom_range(0, 49152)) - 24576),
                        16'(int'($urandom_range(0, 49152)) - 24576),
                        16'($urandom_range(160, 16000)));
        end
        n = $urandom_range(4, 36);
        repeat (n)
            push_tick(pick_dt());
    endtask

    // wait until every pushed word is taken and answered
    task automatic drain_all();
        while (items_accepted != items_pushed || ball_expect.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        int writes_seen;
        writes_seen = regs_written;
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        while (regs_written == writes_seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // settle the block, then rewrite every register
    task automatic load_settings(input int g, input int d, input int r, input int rad,
                                 input int w, input int h, input int ms);
        drain_all();
        repeat (20) @(negedge clk);
        write_reg(bps_pkg::CFG_GRAVITY, 16'(g));
        write_reg(bps_pkg::CFG_DRAG, 16'(d));
        write_reg(bps_pkg::CFG_RESTITUTION, 16'(r));
        write_reg(bps_pkg::CFG_RADIUS, 16'(rad));
        write_reg(bps_pkg::CFG_WIDTH, 16'(w));
        write_reg(bps_pkg::CFG_HEIGHT, 16'(h));
        write_reg(bps_pkg::CFG_MIN_SPEED, 16'(ms));
        settings_used++;
    endtask

    // random phase: mostly well-formed flights, some wild ones and loose noise
    task automatic run_phase(input bit drain_each);
        int target, r;
        target = items_pushed + ITEMS_PER_PHASE;
        while (items_pushed < target)
        begin
            calm_stretch = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
            begin
                queue_flight(1'b0);
            end
            else if (r < 90)
            begin
                queue_flight(1'b1);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 1))
                        push_tick(16'($urandom));
                    else
                        push_launch(24'($urandom), 24'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom));
                end
            end
            // wait for a full drain, or until at most eight words are pending
            if (drain_each)
                drain_all();
            else
                while (pending_items.size() > 8)
                    @(negedge clk);
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm_stretch  = 1'b0;
        grav_q      = longint'(bps_pkg::GRAVITY_RST);
        drag_q      = longint'(bps_pkg::DRAG_RST);
        bounce_q    = longint'(bps_pkg::RESTITUTION_RST);
        radius_px   = longint'(bps_pkg::RADIUS_RST);
        right_px    = longint'(bps_pkg::WIDTH_RST);
        floor_px    = longint'(bps_pkg::HEIGHT_RST);
        min_speed_q = longint'(bps_pkg::MIN_SPEED_RST);
        ball_x = 0;
        ball_y = 0;
        heading_x = 0;
        heading_y = 0;
        ball_speed = 0;
        ball_seen = 1'b0;
        settings_used = 1;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed: zero ball, then one that starts off the left edge
        push_launch(24'h000000, 24'h000000, 16'h0000, 16'h0000, 16'h0000);
        push_tick(16'd1092);
        push_launch(24'(-10 * 256), 24'(200 * 256), 16'd8192, 16'd0, 16'd1600);
        repeat (3)
            push_tick(16'hFFFF);
        // left wall, right wall, floor, top
        push_launch(24'(30 * 256), 24'(240 * 256), -16'sd16384, 16'd0, 16'd4000);
        push_tick(16'd8192);
        push_launch(24'(1270 * 256), 24'(240 * 256), 16'd16384, 16'd0, 16'd4000);
        push_tick(16'd8192);
        push_launch(24'(640 * 256), 24'(470 * 256), 16'd0, 16'd16384, 16'd4000);
        push_tick(16'd8192);
        push_launch(24'(640 * 256), 24'(25 * 256), 16'd0, -16'sd16384, 16'd4000);
        push_tick(16'd8192);
        // two walls at once, top-left and bottom-right corners
        push_launch(24'(25 * 256), 24'(25 * 256), -16'sd16384, -16'sd16384, 16'd4000);
        push_tick(16'd8192);
        push_launch(24'(1275 * 256), 24'(475 * 256), 16'd16384, 16'd16384, 16'd4000);
        push_tick(16'd8192);
        // speed test exactly at the limit, then just above with a zero time step
        push_launch(24'(640 * 256), 24'(240 * 256), 16'd82, 16'd0, 16'd1600);
        push_tick(16'd1092);
        push_launch(24'(640 * 256), 24'(240 * 256), 16'd83, 16'd0, 16'd1600);
        push_tick(16'd0);
        // saturation at both ends
        push_launch(24'h7FFFFF, 24'h7FFFFF, 16'h7FFF, 16'h7FFF, 16'hFFFF);
        push_tick(16'hFFFF);
        push_launch(24'h800000, 24'h800000, 16'h8000, 16'h8000, 16'hFFFF);
        push_tick(16'hFFFF);
        drain_all();

        // random phases over several register settings
        run_phase(1'b0);
        load_settings(32767, 65535, 65535, 4095, 32767, 32767, 32767);
        run_phase(1'b0);
        load_settings(0, 0, 0, 0, 0, 0, 0);
        run_phase(1'b0);
        load_settings(6144, 65535, 32768, 4, 64, 48, 0);
        run_phase(1'b0);
        load_settings($urandom_range(0, 32767), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 4095),
                      $urandom_range(1, 32767), $urandom_range(1, 32767),
                      $urandom_range(0, 32767));
        write_reg(CFG_SPARE_IDX, 16'($urandom));
        run_phase(1'b0);
        load_settings(int'(bps_pkg::GRAVITY_RST), int'(bps_pkg::DRAG_RST),
                      int'(bps_pkg::RESTITUTION_RST), int'(bps_pkg::RADIUS_RST),
                      int'(bps_pkg::WIDTH_RST), int'(bps_pkg::HEIGHT_RST),
                      int'(bps_pkg::MIN_SPEED_RST));
        run_phase(1'b1);
        load_settings($urandom_range(0, 32767), $urandom_range(60000, 65535),
                      $urandom_range(0, 65535), $urandom_range(0, 63),
                      $urandom_range(100, 400), $urandom_range(100, 400),
                      $urandom_range(0, 200));
        run_phase(1'b0);
        load_settings($urandom_range(0, 32767), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), $urandom_range(1000, 4095),
                      $urandom_range(1, 32767), $urandom_range(1, 32767),
                      $urandom_range(0, 4000));
        run_phase(1'b0);

        // wrap up
        calm_stretch = 1'b0;
        drain_all();
        repeat (30) @(negedge clk);
        $display("covered %0d launches and %0d ticks over %0d register settings",
                 launches_done, ticks_done, settings_used);
        $display("%0d words checked, %0d moving, %0d on screen, %0d mismatches",
                 words_checked, moving_seen, visible_seen, error_count);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
